// ===== src/k_combination_generator_defines.svh =====
// assertion macros of the port-level checker of the combination generator
// no dependencies; included by kcg_checker.sv
`ifndef K_COMBINATION_GENERATOR_DEFINES_SVH
`define K_COMBINATION_GENERATOR_DEFINES_SVH

// generic clocked assertion, disabled while the active-low reset is low
`define KCG_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define KCG_ASSERT(lbl, prop, msg) \
    `KCG_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== src/kcg_pkg.sv =====
// shared types and constants of the k-combination generator
// no dependencies; used by the result interface, the top level and the checker
package kcg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SET_SIZE_W = 7;
    localparam int CHOOSE_W   = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]           t_status;

    localparam t_cfg_idx REG_SET_SIZE     = 2'd0;
    localparam t_cfg_idx REG_CHOOSE_COUNT = 2'd1;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_R_GT_N    = 2'd1;
    localparam t_status ST_EXHAUSTED = 2'd2;

endpackage

// ===== src/kcg_if.sv =====
// valid/ready channels of the combination generator: request and result
// depends on kcg_pkg for the status type
interface kcg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface kcg_res_if
    import kcg_pkg::*;
#(
    parameter int EW = 7,
    parameter int PW = 4
);
    logic          valid;
    logic          ready;
    logic [EW-1:0] element;
    logic [PW-1:0] position;
    logic          last_in_row;
    logic          final_row;
    t_status       status;

    modport source (output valid, output element, output position, output last_in_row,
                    output final_row, output status, input ready);
    modport sink   (input valid, input element, input position, input last_in_row,
                    input final_row, input status, output ready);
endinterface

// ===== src/kcg_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
module kcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/k_combination_generator.sv =====
// top level of the lexicographic k-combination generator
// depends on kcg_pkg, kcg_if (request and result channels) and kcg_ram
//
// Usage: write set_size (index 0) and choose_count (index 1) on the config port
// while idle; a write to either index restarts at the first subset. Each transfer
// on i_req (restart=1 goes back to the first subset first) produces one row
// on o_res: r results, in position order, one element per cycle while the
// receiver takes them, last_in_row on the last, final_row on every result of
// the last subset. When r exceeds n, or after the last subset until a restart,
// a request gives a single status result. After a request is accepted, the
// pivot scan reads the index RAM from position r-1 downward, one entry a cycle,
// until it finds an index below its maximum or reaches position 0, then emits
// r results at one per cycle while the receiver takes them, rewriting the
// indices from the pivot on through the same RAM port pair. i_req.ready is
// high only between requests.
// Reset restores n = 1, r = 1 and the first subset; index entries never
// written since a restart read as their position. A stalled receiver holds
// the output register and freezes the emission, nothing is lost.
module k_combination_generator
    import kcg_pkg::*;
#(
    parameter int MAX_SET    = 64,
    parameter int MAX_CHOOSE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    kcg_req_if.sink               i_req,
    kcg_res_if.source             o_res
);
    localparam int IW = (MAX_SET > 2) ? $clog2(MAX_SET) : 1;
    localparam int NW = $clog2(MAX_SET + 1);
    localparam int EW = $clog2(MAX_SET + 1);
    localparam int AW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
    localparam int RW = $clog2(MAX_CHOOSE + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [SET_SIZE_W-1:0] r_set_size, n_set_size;
    logic [CHOOSE_W-1:0]   r_choose, n_choose;
    logic [MAX_CHOOSE-1:0] r_valid, n_valid;
    logic                  r_exh, n_exh;
    logic [AW-1:0]         r_pivot, n_pivot;
    logic                  r_fin, n_fin;
    logic [IW-1:0]         r_wval, n_wval;
    logic [AW-1:0]         r_rd_addr, n_rd_addr;
    logic                  r_rd_valid, n_rd_valid;
    t_status               r_stat, n_stat;
    logic                  r_out_valid, n_out_valid;
    logic [EW-1:0]         r_out_el, n_out_el;
    logic [AW-1:0]         r_out_pos, n_out_pos;
    logic                  r_out_last, n_out_last;
    logic                  r_out_fin, n_out_fin;
    t_status               r_out_st, n_out_st;

    logic [NW-1:0] set_eff;
    logic [RW-1:0] choose_eff;
    logic          choose_gt_set;
    logic [AW-1:0] last_pos;
    logic [NW-1:0] gap;
    logic [NW-1:0] limit;
    logic [IW-1:0] idx_q;
    logic [IW-1:0] ram_q;
    logic          ram_re, ram_we;
    logic [AW-1:0] ram_raddr, ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic          accept;
    logic          slot_free;
    logic          row_last;

    // effective n and r with saturation, r of zero acts as one
    always_comb begin
        if (32'(r_set_size) > MAX_SET) begin
            set_eff = NW'(MAX_SET);
        end else begin
            set_eff = NW'(r_set_size);
        end
        if (32'(r_choose) > MAX_CHOOSE) begin
            choose_eff = RW'(MAX_CHOOSE);
        end else if (r_choose == '0) begin
            choose_eff = RW'(1);
        end else begin
            choose_eff = RW'(r_choose);
        end
    end

    assign choose_gt_set = 32'(choose_eff) > 32'(set_eff);
    assign last_pos      = AW'(choose_eff - RW'(1));
    assign gap           = set_eff - NW'(choose_eff);
    assign limit         = gap + NW'(r_rd_addr);
    // entries not written since the last restart hold their position
    assign idx_q         = r_rd_valid ? ram_q : IW'(r_rd_addr);
    assign accept        = i_req.valid && i_req.ready;
    assign slot_free     = !r_out_valid || o_res.ready;
    assign row_last      = r_rd_addr == last_pos;

    kcg_ram #(
        .WIDTH(IW),
        .DEPTH(MAX_CHOOSE)
    ) u_index_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_set_size  = r_set_size;
        n_choose    = r_choose;
        n_valid     = r_valid;
        n_exh       = r_exh;
        n_pivot     = r_pivot;
        n_fin       = r_fin;
        n_wval      = r_wval;
        n_rd_addr   = r_rd_addr;
        n_rd_valid  = r_rd_valid;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_el    = r_out_el;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        n_out_fin   = r_out_fin;
        n_out_st    = r_out_st;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_rd_addr;
        ram_wdata   = r_wval;

        if (i_cfg_we) begin
            if (i_cfg_idx == REG_SET_SIZE) begin
                n_set_size = SET_SIZE_W'(i_cfg_data);
                n_valid    = '0;
                n_exh      = 1'b0;
            end else if (i_cfg_idx == REG_CHOOSE_COUNT) begin
                n_choose = CHOOSE_W'(i_cfg_data);
                n_valid  = '0;
                n_exh    = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.restart) begin
                        n_valid = '0;
                        n_exh   = 1'b0;
                    end
                    if (choose_gt_set) begin
                        n_stat  = ST_R_GT_N;
                        n_state = S_STAT;
                    end else if (r_exh && !i_req.restart) begin
                        n_stat  = ST_EXHAUSTED;
                        n_state = S_STAT;
                    end else begin
                        // start the pivot scan at the rightmost position
                        ram_re     = 1'b1;
                        ram_raddr  = last_pos;
                        n_rd_addr  = last_pos;
                        n_rd_valid = !i_req.restart && r_valid[last_pos];
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (NW'(idx_q) < limit) begin
                    n_pivot    = r_rd_addr;
                    n_fin      = 1'b0;
                    n_wval     = idx_q + IW'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    n_rd_addr  = '0;
                    n_rd_valid = r_valid[0];
                    n_state    = S_EMIT;
                end else if (r_rd_addr == '0) begin
                    // every index at its maximum: this is the last subset
                    n_fin      = 1'b1;
                    n_exh      = 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    n_rd_addr  = '0;
                    n_rd_valid = r_valid[0];
                    n_state    = S_EMIT;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_rd_addr - AW'(1);
                    n_rd_addr  = r_rd_addr - AW'(1);
                    n_rd_valid = r_valid[r_rd_addr - AW'(1)];
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_el    = EW'(idx_q) + EW'(1);
                    n_out_pos   = r_rd_addr;
                    n_out_last  = row_last;
                    n_out_fin   = r_fin;
                    n_out_st    = ST_OK;
                    // old value is out, rewrite pivot and everything after it
                    if (!r_fin && (r_rd_addr >= r_pivot)) begin
                        ram_we             = 1'b1;
                        n_valid[r_rd_addr] = 1'b1;
                        n_wval             = r_wval + IW'(1);
                    end
                    if (row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = r_rd_addr + AW'(1);
                        n_rd_addr  = r_rd_addr + AW'(1);
                        n_rd_valid = r_valid[r_rd_addr + AW'(1)];
                    end
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_el    = '0;
                    n_out_pos   = '0;
                    n_out_last  = 1'b1;
                    n_out_fin   = 1'b0;
                    n_out_st    = r_stat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set_size  <= SET_SIZE_W'(1);
            r_choose    <= CHOOSE_W'(1);
            r_valid     <= '0;
            r_exh       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_set_size  <= n_set_size;
            r_choose    <= n_choose;
            r_valid     <= n_valid;
            r_exh       <= n_exh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pivot    <= n_pivot;
        r_fin      <= n_fin;
        r_wval     <= n_wval;
        r_rd_addr  <= n_rd_addr;
        r_rd_valid <= n_rd_valid;
        r_stat     <= n_stat;
        r_out_el   <= n_out_el;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
        r_out_fin  <= n_out_fin;
        r_out_st   <= n_out_st;
    end

    assign i_req.ready       = r_state == S_IDLE;
    assign o_res.valid       = r_out_valid;
    assign o_res.element     = r_out_el;
    assign o_res.position    = r_out_pos;
    assign o_res.last_in_row = r_out_last;
    assign o_res.final_row   = r_out_fin;
    assign o_res.status      = r_out_st;
endmodule

// ===== src/kcg_checker.sv =====
// port-level checker of the combination generator, bound to the top level
// depends on kcg_pkg and k_combination_generator_defines.svh
`include "k_combination_generator_defines.svh"

module kcg_checker
    import kcg_pkg::*;
#(
    parameter int MAX_SET    = 64,
    parameter int MAX_CHOOSE = 16
) (
    input logic                                             i_clk,
    input logic                                             i_rst_n,
    input logic                                             i_req_valid,
    input logic                                             i_req_ready,
    input logic                                             i_res_valid,
    input logic                                             i_res_ready,
    input logic [$clog2(MAX_SET + 1)-1:0]                   i_element,
    input logic [(MAX_CHOOSE > 1 ? $clog2(MAX_CHOOSE) : 1)-1:0] i_position,
    input logic                                             i_last,
    input logic                                             i_fin,
    input t_status                                          i_status
);
    // a held result keeps its element, position and status
    `KCG_ASSERT(a_res_hold, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_element) && $stable(i_position) && $stable(i_status), "result changed while stalled")

    // a status result is a single blank result
    `KCG_ASSERT(a_status_blank, i_res_valid && (i_status != ST_OK) |-> (i_element == '0) && (i_position == '0) && i_last && !i_fin, "status result not blank")

    // an ok result carries an element of the base set
    `KCG_ASSERT(a_ok_element, i_res_valid && (i_status == ST_OK) |-> (i_element != '0) && (32'(i_element) <= MAX_SET), "element out of range")

    // after a request transfer the block is busy
    `KCG_ASSERT(a_busy_after_req, i_req_valid && i_req_ready |=> !i_req_ready, "ready right after request")
endmodule

bind k_combination_generator kcg_checker #(
    .MAX_SET   (MAX_SET),
    .MAX_CHOOSE(MAX_CHOOSE)
) u_kcg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_element  (o_res.element),
    .i_position (o_res.position),
    .i_last     (o_res.last_in_row),
    .i_fin      (o_res.final_row),
    .i_status   (o_res.status)
);

// ===== sim/k_combination_generator_tb.sv =====
// self-checking testbench of the k-combination generator: directed table, then random phases
// depends on kcg_pkg, kcg_if (request and result channels) and k_combination_generator
module k_combination_generator_tb;
    import kcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SET       = 64;
    localparam int MAX_CHOOSE    = 16;
    localparam int CLK_HALF      = 2;
    localparam int RST_CYCLES    = 10;
    localparam int SETTLE_CYCLES = 2 * MAX_CHOOSE + 4;
    localparam int RAND_ITEMS    = 300;
    localparam int CALM_ITEMS    = 40;
    localparam int TIMEOUT_NS    = 4_000_000;

    // indexes outside the register list, writes there must be ignored
    localparam t_cfg_idx REG_UNUSED_A = 2'd2;
    localparam t_cfg_idx REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [6:0] element;
        logic [3:0] position;
        logic       last_in_row;
        logic       final_row;
        t_status    status;
    } t_subset_result;

    localparam t_subset_result RES_NONE = '0;
    localparam t_subset_result RES_ONLY = '{7'd1, 4'd0, 1'b1, 1'b1, ST_OK};
    localparam t_subset_result RES_RGN  = '{7'd0, 4'd0, 1'b1, 1'b0, ST_R_GT_N};
    localparam t_subset_result RES_EXH  = '{7'd0, 4'd0, 1'b1, 1'b0, ST_EXHAUSTED};

    typedef enum logic [1:0] {PLAN_KEEP, PLAN_REGS, PLAN_SPARE} t_plan_cfg;

    typedef struct packed {
        t_plan_cfg      mode;
        logic [6:0]     n_val;
        logic [6:0]     r_val;
        logic           restart;
        logic           typed;
        t_subset_result want;
    } t_plan_row;

    localparam int PLAN_LEN = 23;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b1, RES_ONLY},  // n = r = 1 out of reset
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b1, RES_EXH},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b1, 1'b1, RES_ONLY},
        '{PLAN_REGS,  7'd0,   7'd1,   1'b0, 1'b1, RES_RGN},   // empty base set
        '{PLAN_REGS,  7'd3,   7'd5,   1'b1, 1'b1, RES_RGN},
        '{PLAN_REGS,  7'd4,   7'd2,   1'b0, 1'b0, RES_NONE},  // walk all of 4 choose 2
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b1, RES_EXH},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b1, 1'b0, RES_NONE},
        '{PLAN_SPARE, 7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},  // no restart expected
        '{PLAN_REGS,  7'd127, 7'd127, 1'b0, 1'b0, RES_NONE},  // both saturate
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b0, RES_NONE},
        '{PLAN_REGS,  7'd64,  7'd0,   1'b0, 1'b0, RES_NONE},  // r of zero acts as one
        '{PLAN_REGS,  7'd16,  7'd16,  1'b0, 1'b0, RES_NONE},  // single subset
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b0, 1'b1, RES_EXH},
        '{PLAN_REGS,  7'd64,  7'd16,  1'b1, 1'b0, RES_NONE},
        '{PLAN_REGS,  7'd65,  7'd17,  1'b0, 1'b0, RES_NONE},
        '{PLAN_REGS,  7'd2,   7'd2,   1'b0, 1'b0, RES_NONE},
        '{PLAN_KEEP,  7'd0,   7'd0,   1'b1, 1'b0, RES_NONE}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    kcg_req_if req_ch ();
    kcg_res_if res_ch ();

    k_combination_generator #(
        .MAX_SET    (MAX_SET),
        .MAX_CHOOSE (MAX_CHOOSE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // generator state as seen by the predictor
    logic [6:0]     cur_set_size = 7'd1;
    logic [4:0]     cur_choose   = 5'd1;
    logic [5:0]     cols [MAX_CHOOSE];
    logic           all_done;
    t_subset_result fresh_row [$];
    t_subset_result due_elements [$];
    int             mismatch_count = 0;
    bit             calm = 1'b0;
    int unsigned    sink_stall = 0;

    function automatic void rewind_subset();
        int i;
        for (i = 0; i < MAX_CHOOSE; i++) cols[i] = 6'(i);
        all_done = 1'b0;
    endfunction

    // results of one request, left in fresh_row; advances the subset
    function automatic void step_subset(input logic rs);
        int   n, r, piv, i;
        logic fin;
        n = (cur_set_size > MAX_SET) ? MAX_SET : int'(cur_set_size);
        r = (cur_choose > MAX_CHOOSE) ? MAX_CHOOSE : int'(cur_choose);
        if (r == 0) r = 1;
        fresh_row.delete();
        if (rs) rewind_subset();
        if (r > n) begin
            fresh_row.push_back(RES_RGN);
            return;
        end
        if (all_done) begin
            fresh_row.push_back(RES_EXH);
            return;
        end
        // rightmost column still below its ceiling
        piv = r - 1;
        while (piv >= 0 && int'(cols[piv]) >= n - r + piv) piv--;
        fin = (piv < 0);
        for (i = 0; i < r; i++)
            fresh_row.push_back('{7'(cols[i]) + 7'd1, 4'(i), logic'(i == r - 1),
                                  fin, ST_OK});
        if (fin) begin
            all_done = 1'b1;
        end else begin
            cols[piv] = cols[piv] + 6'd1;
            for (i = piv + 1; i < r; i++) cols[i] = cols[piv] + 6'(i - piv);
        end
    endfunction

    // leaves the write enable high; the caller lowers it after its last write
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            REG_SET_SIZE: begin
                cur_set_size = d;
                rewind_subset();
            end
            REG_CHOOSE_COUNT: begin
                cur_choose = d[CHOOSE_W-1:0];
                rewind_subset();
            end
            default: ;
        endcase
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (due_elements.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_request(input logic rs, input logic typed,
                                input t_subset_result want);
        int gap;
        int j;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= rs;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        step_subset(rs);
        if (typed) due_elements.push_back(want);
        else for (j = 0; j < fresh_row.size(); j++) due_elements.push_back(fresh_row[j]);
    endtask

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            sink_stall--;
            res_ch.ready <= (sink_stall == 0);
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(1, 9);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_subset_result got;
        t_subset_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.element, res_ch.position, res_ch.last_in_row,
                    res_ch.final_row, res_ch.status};
            if (due_elements.size() == 0) begin
                $display("%0t: transfer with nothing pending, %s%0d pos=%0d last=%0b fin=%0b st=%0d",
                         $time, "actual el=", got.element, got.position,
                         got.last_in_row, got.final_row, got.status);
                mismatch_count++;
            end else begin
                want = due_elements.pop_front();
                if (got !== want) begin
                    $display("%0t: expected el=%0d pos=%0d last=%0b fin=%0b st=%0d",
                             $time, want.element, want.position, want.last_in_row,
                             want.final_row, want.status);
                    $display("%0t:   actual el=%0d pos=%0d last=%0b fin=%0b st=%0d",
                             $time, got.element, got.position, got.last_in_row,
                             got.final_row, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int          k, i, rand_sent, shape, cfg_kind, phase_len;
        logic [6:0]  n_val, r_val;
        bit          noisy;
        logic        rs;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_SET_SIZE;
        i_cfg_data     <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        rewind_subset();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < PLAN_LEN; k++) begin
            case (PLAN[k].mode)
                PLAN_REGS: begin
                    quiesce();
                    cfg_write(REG_SET_SIZE, PLAN[k].n_val);
                    cfg_write(REG_CHOOSE_COUNT, PLAN[k].r_val);
                    i_cfg_we <= 1'b0;
                end
                PLAN_SPARE: begin
                    quiesce();
                    cfg_write(REG_UNUSED_A, 7'h7F);
                    cfg_write(REG_UNUSED_B, 7'h2A);
                    i_cfg_we <= 1'b0;
                end
                default: ;
            endcase
            send_request(PLAN[k].restart, PLAN[k].typed, PLAN[k].want);
        end

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            shape = $urandom_range(0, 9);
            if (shape <= 5) begin
                n_val     = 7'($urandom_range(1, 8));
                r_val     = 7'($urandom_range(1, n_val));
                phase_len = $urandom_range(6, 40);
            end else if (shape == 6) begin
                // mostly r above n, r of zero now and then
                n_val     = 7'($urandom_range(0, 5));
                r_val     = 7'($urandom_range(0, 31));
                phase_len = $urandom_range(3, 10);
            end else if (shape == 7) begin
                n_val     = 7'($urandom_range(9, 127));
                r_val     = 7'($urandom_range(1, 2));
                phase_len = $urandom_range(10, 40);
            end else begin
                n_val     = 7'($urandom_range(16, 127));
                r_val     = 7'($urandom_range(8, 31));
                phase_len = $urandom_range(2, 5);
            end
            // junk in the bits above the choose field
            r_val[6:5] = 2'($urandom_range(0, 3));

            cfg_kind = $urandom_range(0, 7);
            if (cfg_kind == 1) begin
                quiesce();
                cfg_write($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                          7'($urandom_range(0, 127)));
                i_cfg_we <= 1'b0;
            end else if (cfg_kind != 0) begin
                quiesce();
                if ($urandom_range(0, 1)) begin
                    cfg_write(REG_CHOOSE_COUNT, r_val);
                    cfg_write(REG_SET_SIZE, n_val);
                end else begin
                    cfg_write(REG_SET_SIZE, n_val);
                    if ($urandom_range(0, 3) == 0)
                        cfg_write(REG_UNUSED_B, 7'($urandom_range(0, 127)));
                    cfg_write(REG_CHOOSE_COUNT, r_val);
                end
                i_cfg_we <= 1'b0;
            end

            noisy = ($urandom_range(0, 7) == 0);
            for (i = 0; i < phase_len && rand_sent < RAND_ITEMS; i++) begin
                calm = (rand_sent >= RAND_ITEMS - CALM_ITEMS);
                rs   = noisy ? logic'($urandom_range(0, 1))
                             : logic'($urandom_range(0, 19) == 0);
                send_request(rs, 1'b0, RES_NONE);
                rand_sent++;
            end
        end

        quiesce();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/kcg_pkg.sv
src/kcg_if.sv
src/kcg_ram.sv
src/k_combination_generator.sv
src/kcg_checker.sv
sim/k_combination_generator_tb.sv
